FILE: hw/rtl/i2cms_pkg.sv
// Shared definitions for the I2C master sequence engine.
// Holds item codes, status codes, the default store depth and the result record type.
// Used by the engine and by its checker.
package i2cms_pkg;

   localparam int I2CMS_SEQ_DEPTH = 64;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_EVENT = 2'd2;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   localparam logic [1:0] STATUS_AVAILABLE = 2'd0;
   localparam logic [1:0] STATUS_BUSY      = 2'd1;
   localparam logic [1:0] STATUS_ERROR     = 2'd2;

   typedef struct packed {
      logic       accepted;
      logic       drive_start;
      logic       drive_restart;
      logic       drive_stop;
      logic       no_ack_next;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [5:0] rx_index;
      logic [7:0] rx_data;
   } i2cms_res_type;

endpackage

FILE: hw/rtl/i2c_master_sequence_engine.sv
// Top level of the I2C master sequence engine: command store, sequencer and result register.
// Depends on i2cms_pkg.
//
// Each request item is a sequence element load, a start request or a controller event, and
// gives exactly one result item. The block takes one item at a time: req_tready is low from
// acceptance until the result has moved into the output register. A load, a refused start,
// an ignored event or an event settled without a store read goes straight to the result
// state; a start first sends element 0 unless arbitration is lost; a store-reading event
// passes through an element state, a restart also a byte state. When an event opens a run
// of reads, the sequencer walks the store through its single read port, one element a cycle,
// to count the run. A result that is not taken holds the output register; the next item is
// still accepted and waits only if it finishes before the previous result has gone.
module i2c_master_sequence_engine
   import i2cms_pkg::*;
#(
   parameter int SEQ_DEPTH = I2CMS_SEQ_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // element_index[5:0], element_kind[7:6], element_byte[15:8], seq_length[22:16],
   // arbitration_lost[23], nack_received[24], rx_byte[32:25], zero fill [39:33]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], accepted[2], drive_start[3], drive_restart[4], drive_stop[5],
   // transmit_mode[6], no_ack_next[7], tx_valid[8], tx_byte[16:9], rx_valid[17],
   // rx_index[23:18], rx_data[31:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int PW = $clog2(SEQ_DEPTH + 2);
   localparam int CW = (PW > 7) ? PW : 7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_CHKRS,
      S_ELEM,
      S_RSBYTE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [PW-1:0]   position_ff, position_in;
   logic [PW-1:0]   end_ff, end_in;
   logic [1:0]      status_ff, status_in;
   logic            reading_ff, reading_in;
   logic [PW-1:0]   left_ff, left_in;
   logic [PW-1:0]   extra_ff, extra_in;
   logic [5:0]      rcnt_ff, rcnt_in;
   i2cms_res_type   res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [9:0]      mem [SEQ_DEPTH];
   logic [9:0]      mem_q_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_addr;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   logic [9:0]      mem_wd;

   logic [5:0]      req_index;
   logic [1:0]      req_kind;
   logic [7:0]      req_byte;
   logic [6:0]      req_len;
   logic            req_arb;
   logic            req_nack;
   logic [7:0]      req_rx;
   logic [CW-1:0]   len_c;
   logic [CW-1:0]   len_sat;
   logic [1:0]      q_kind;
   logic [PW-1:0]   pos_next;
   logic [PW-1:0]   scan_next;
   logic [PW-1:0]   extra_inc;

   assign req_index = req_tdata[5:0];
   assign req_kind  = req_tdata[7:6];
   assign req_byte  = req_tdata[15:8];
   assign req_len   = req_tdata[22:16];
   assign req_arb   = req_tdata[23];
   assign req_nack  = req_tdata[24];
   assign req_rx    = req_tdata[32:25];

   assign len_c   = CW'(req_len);
   assign len_sat = (len_c == '0) ? CW'(1) :
                    ((len_c > CW'(SEQ_DEPTH)) ? CW'(SEQ_DEPTH) : len_c);

   assign q_kind    = mem_q_ff[9:8];
   assign pos_next  = position_ff + PW'(1);
   assign scan_next = rd_ptr_ff + PW'(1);
   assign extra_inc = extra_ff + PW'(1);

   assign mem_wa = AW'(req_index);
   assign mem_wd = {req_kind, req_byte};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff  <= mem[rd_addr[AW-1:0]];
      rd_ptr_ff <= rd_addr;
   end

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      end_in       = end_ff;
      status_in    = status_ff;
      reading_in   = reading_ff;
      left_in      = left_ff;
      extra_in     = extra_ff;
      rcnt_in      = rcnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      mem_we       = 1'b0;
      req_tready   = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_in   = '0;
               state_in = S_DONE;
               case (req_tuser)
                  MODE_LOAD: begin
                     mem_we = (32'(req_index) < SEQ_DEPTH);
                  end
                  MODE_START: begin
                     if (status_ff != STATUS_BUSY) begin
                        res_in.accepted    = 1'b1;
                        res_in.drive_start = 1'b1;
                        end_in      = PW'(len_sat);
                        position_in = '0;
                        reading_in  = 1'b0;
                        left_in     = '0;
                        if (req_arb) begin
                           res_in.drive_stop = 1'b1;
                           status_in = STATUS_ERROR;
                        end else begin
                           status_in = STATUS_BUSY;
                           state_in  = S_START;
                        end
                     end
                  end
                  MODE_EVENT: begin
                     if (status_ff == STATUS_BUSY) begin
                        if (req_arb) begin
                           res_in.drive_stop = 1'b1;
                           status_in  = STATUS_ERROR;
                           reading_in = 1'b0;
                           left_in    = '0;
                        end else if (reading_ff) begin
                           res_in.rx_valid = 1'b1;
                           res_in.rx_index = rcnt_ff;
                           res_in.rx_data  = req_rx;
                           rcnt_in = rcnt_ff + 6'd1;
                           if (left_ff != '0) begin
                              res_in.no_ack_next = (left_ff == PW'(1));
                              left_in     = left_ff - PW'(1);
                              position_in = pos_next;
                           end else if (position_ff < end_ff) begin
                              rd_addr  = position_ff;
                              state_in = S_CHKRS;
                           end else begin
                              res_in.drive_stop = 1'b1;
                              status_in  = STATUS_AVAILABLE;
                              reading_in = 1'b0;
                              left_in    = '0;
                           end
                        end else if (position_ff >= end_ff) begin
                           res_in.drive_stop = 1'b1;
                           status_in = STATUS_AVAILABLE;
                           left_in   = '0;
                        end else if (req_nack) begin
                           res_in.drive_stop = 1'b1;
                           status_in = STATUS_ERROR;
                           left_in   = '0;
                        end else begin
                           rd_addr  = position_ff;
                           state_in = S_ELEM;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            res_in.tx_valid = 1'b1;
            res_in.tx_byte  = mem_q_ff[7:0];
            position_in     = PW'(1);
            state_in        = S_DONE;
         end
         S_CHKRS, S_ELEM: begin
            if (q_kind == KIND_RESTART) begin
               res_in.drive_restart = 1'b1;
               reading_in  = 1'b0;
               position_in = pos_next;
               rd_addr     = (pos_next < end_ff) ? pos_next : '0;
               state_in    = S_RSBYTE;
            end else if (state_ff == S_CHKRS) begin
               res_in.drive_stop = 1'b1;
               status_in  = STATUS_AVAILABLE;
               reading_in = 1'b0;
               left_in    = '0;
               state_in   = S_DONE;
            end else if (q_kind == KIND_READ) begin
               if (pos_next < end_ff) begin
                  rd_addr  = pos_next;
                  extra_in = '0;
                  state_in = S_SCAN;
               end else begin
                  reading_in         = 1'b1;
                  left_in            = '0;
                  res_in.no_ack_next = 1'b1;
                  position_in        = pos_next;
                  state_in           = S_DONE;
               end
            end else begin
               res_in.tx_valid = 1'b1;
               res_in.tx_byte  = mem_q_ff[7:0];
               position_in     = pos_next;
               state_in        = S_DONE;
            end
         end
         S_RSBYTE: begin
            res_in.tx_valid = 1'b1;
            res_in.tx_byte  = (position_ff < end_ff) ? mem_q_ff[7:0] : 8'd0;
            position_in     = pos_next;
            state_in        = S_DONE;
         end
         S_SCAN: begin
            if ((q_kind == KIND_READ) && (scan_next < end_ff)) begin
               rd_addr  = scan_next;
               extra_in = extra_inc;
            end else begin
               reading_in         = 1'b1;
               left_in            = (q_kind == KIND_READ) ? extra_inc : extra_ff;
               res_in.no_ack_next = (left_in == '0);
               position_in        = pos_next;
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff.rx_data, res_ff.rx_index, res_ff.rx_valid,
                               res_ff.tx_byte, res_ff.tx_valid, res_ff.no_ack_next,
                               (status_ff == STATUS_BUSY) && !reading_ff,
                               res_ff.drive_stop, res_ff.drive_restart,
                               res_ff.drive_start, res_ff.accepted, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         position_ff  <= '0;
         end_ff       <= '0;
         status_ff    <= STATUS_AVAILABLE;
         reading_ff   <= 1'b0;
         left_ff      <= '0;
         extra_ff     <= '0;
         rcnt_ff      <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         end_ff       <= end_in;
         status_ff    <= status_in;
         reading_ff   <= reading_in;
         left_ff      <= left_in;
         extra_ff     <= extra_in;
         rcnt_ff      <= rcnt_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hw/rtl/i2cms_checker.sv
// Port-level checker for the I2C master sequence engine, bound to its top level.
// Depends on i2cms_pkg.
module i2cms_checker
   import i2cms_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is still in work");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[3] && (rsp_tdata[1:0] != STATUS_AVAILABLE))
      else $error("accepted start without start condition");

   a_stop_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> (rsp_tdata[1:0] != STATUS_BUSY) && !rsp_tdata[6])
      else $error("stop reported while still busy");

   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8] || (rsp_tdata[16:9] == 8'd0)) &&
                     (rsp_tdata[17] || (rsp_tdata[31:18] == 14'd0)))
      else $error("byte fields set without their valid flag");

endmodule

bind i2c_master_sequence_engine i2cms_checker u_i2cms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
